FILE: hw/rtl/modbus_request_framer_unit_assert.svh
// assertion macros used by the read-request framer byte sequencer
`ifndef MODBUS_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define MODBUS_REQUEST_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication, expects clock and reset in scope
`define MBRF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, expects clock and reset in scope
`define MBRF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mbrf_pkg.sv
// types, frame constants and crc helper for the read-request framer
`default_nettype none

package mbrf_pkg;

   // request descriptor handed from the front end to the byte sequencer
   typedef struct packed {
      logic [31:0] serial;
      logic [15:0] seq;
      logic [7:0]  count;
      logic [15:0] start;
   } request_desc_type;

   // byte positions inside the frame
   localparam logic [5:0] POS_START      = 6'd0;
   localparam logic [5:0] POS_LEN_LO     = 6'd1;
   localparam logic [5:0] POS_LEN_HI     = 6'd2;
   localparam logic [5:0] POS_CTRL_LO    = 6'd3;
   localparam logic [5:0] POS_CTRL_HI    = 6'd4;
   localparam logic [5:0] POS_SEQ_LO     = 6'd5;
   localparam logic [5:0] POS_SEQ_HI     = 6'd6;
   localparam logic [5:0] POS_SERIAL_0   = 6'd7;
   localparam logic [5:0] POS_SERIAL_1   = 6'd8;
   localparam logic [5:0] POS_SERIAL_2   = 6'd9;
   localparam logic [5:0] POS_SERIAL_3   = 6'd10;
   localparam logic [5:0] POS_FTYPE      = 6'd11;
   localparam logic [5:0] POS_ZERO_FIRST = 6'd12;
   localparam logic [5:0] POS_ZERO_LAST  = 6'd25;
   localparam logic [5:0] POS_MB_SLAVE   = 6'd26;
   localparam logic [5:0] POS_MB_FUNC    = 6'd27;
   localparam logic [5:0] POS_MB_REG_HI  = 6'd28;
   localparam logic [5:0] POS_MB_REG_LO  = 6'd29;
   localparam logic [5:0] POS_MB_CNT_HI  = 6'd30;
   localparam logic [5:0] POS_MB_CNT_LO  = 6'd31;
   localparam logic [5:0] POS_CRC_LO     = 6'd32;
   localparam logic [5:0] POS_CRC_HI     = 6'd33;
   localparam logic [5:0] POS_SUM        = 6'd34;
   localparam logic [5:0] POS_END        = 6'd35;

   // fixed byte values
   localparam logic [7:0] START_BYTE   = 8'hA5;
   localparam logic [7:0] LENGTH_BYTE  = 8'd23;
   localparam logic [7:0] CTRL_LO      = 8'h10;
   localparam logic [7:0] CTRL_HI      = 8'h45;
   localparam logic [7:0] FTYPE_BYTE   = 8'h02;
   localparam logic [7:0] MB_SLAVE     = 8'h01;
   localparam logic [7:0] MB_FUNC_READ = 8'h03;
   localparam logic [7:0] END_BYTE     = 8'h15;

   // reflected crc-16 parameters
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // one byte through the reflected crc-16, bit by bit
   function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mbrf_front.sv
// front end: takes requests, stamps sequence number and serial, feeds the queue
`default_nettype none

module mbrf_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [31:0]                csr_wr_data,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [23:0]                req_tdata,
   input  wire logic                       queue_full,
   output logic                            push,
   output mbrf_pkg::request_desc_type      push_desc
);
   import mbrf_pkg::*;

   logic [31:0] serial_ff, serial_in;
   logic [15:0] seq_ff, seq_in;

   // accept whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // descriptor for the sequencer
   always_comb begin
      push_desc.serial = serial_ff;
      push_desc.seq    = seq_ff;
      push_desc.count  = req_tdata[23:16];
      push_desc.start  = req_tdata[15:0];
   end

   // serial register and sequence counter
   always_comb begin
      serial_in = csr_wr_en ? csr_wr_data : serial_ff;
      seq_in    = push ? seq_ff + 16'd1 : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= '0;
         seq_ff    <= '0;
      end else begin
         serial_ff <= serial_in;
         seq_ff    <= seq_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mbrf_queue.sv
// short descriptor queue between front end and byte sequencer
`default_nettype none

module mbrf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire mbrf_pkg::request_desc_type push_desc,
   input  wire logic                       pop,
   output logic                            full,
   output logic                            head_valid,
   output mbrf_pkg::request_desc_type      head_desc
);
   import mbrf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   request_desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mbrf_back.sv
// byte sequencer: walks the 36 frame bytes, running crc and checksum
`default_nettype none

`include "modbus_request_framer_unit_assert.svh"

module mbrf_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_valid,
   input  wire mbrf_pkg::request_desc_type head_desc,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [7:0]                      rsp_tdata,
   output logic                            rsp_tlast
);
   import mbrf_pkg::*;

   logic [5:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]  rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tlast_ff, rsp_tlast_in;
   logic        load;
   logic [7:0]  byte_val;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // next byte goes into the output register when it is free or draining
   assign load = head_valid && (!rsp_tvalid_ff || rsp_tready);
   assign pop  = load && (idx_ff == POS_END);

   // frame byte at the current position
   always_comb begin
      case (idx_ff) inside
         POS_START:                       byte_val = START_BYTE;
         POS_LEN_LO:                      byte_val = LENGTH_BYTE;
         POS_CTRL_LO:                     byte_val = CTRL_LO;
         POS_CTRL_HI:                     byte_val = CTRL_HI;
         POS_SEQ_LO:                      byte_val = head_desc.seq[7:0];
         POS_SEQ_HI:                      byte_val = head_desc.seq[15:8];
         POS_SERIAL_0:                    byte_val = head_desc.serial[7:0];
         POS_SERIAL_1:                    byte_val = head_desc.serial[15:8];
         POS_SERIAL_2:                    byte_val = head_desc.serial[23:16];
         POS_SERIAL_3:                    byte_val = head_desc.serial[31:24];
         POS_FTYPE:                       byte_val = FTYPE_BYTE;
         POS_MB_SLAVE:                    byte_val = MB_SLAVE;
         POS_MB_FUNC:                     byte_val = MB_FUNC_READ;
         POS_MB_REG_HI:                   byte_val = head_desc.start[15:8];
         POS_MB_REG_LO:                   byte_val = head_desc.start[7:0];
         POS_MB_CNT_LO:                   byte_val = head_desc.count;
         POS_CRC_LO:                      byte_val = crc_ff[7:0];
         POS_CRC_HI:                      byte_val = crc_ff[15:8];
         POS_SUM:                         byte_val = sum_ff;
         POS_END:                         byte_val = END_BYTE;
         POS_LEN_HI, POS_MB_CNT_HI,
         [POS_ZERO_FIRST:POS_ZERO_LAST]:  byte_val = 8'h00;
         default:                         byte_val = 8'h00;
      endcase
   end

   // position advances with each loaded byte; crc and checksum accumulate over their byte ranges
   always_comb begin
      idx_in = idx_ff;
      crc_in = crc_ff;
      sum_in = sum_ff;
      if (load) begin
         idx_in = (idx_ff == POS_END) ? POS_START : idx_ff + 6'd1;
         if (idx_ff == POS_START) begin
            crc_in = CRC_INIT;
            sum_in = 8'h00;
         end else begin
            if ((idx_ff >= POS_MB_SLAVE) && (idx_ff <= POS_MB_CNT_LO)) begin
               crc_in = crc16_step(crc_ff, byte_val);
            end
            if (idx_ff <= POS_CRC_HI) begin
               sum_in = sum_ff + byte_val;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = byte_val;
         rsp_tlast_in  = (idx_ff == POS_END);
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= POS_START;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tlast_ff  <= rsp_tlast_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      sum_ff       <= sum_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // checks
   `MBRF_ASSERT_IMP(a_idx_range, 1'b1, idx_ff <= POS_END, "frame position out of range")
   `MBRF_ASSERT_IMP(a_head_held, idx_ff != POS_START, head_valid,
                    "request left the queue mid-frame")
   `MBRF_ASSERT_IMP(a_last_is_end, rsp_tvalid_ff && rsp_tlast_ff, rsp_tdata_ff == END_BYTE,
                    "last item is not the end byte")
   `MBRF_ASSERT_NXT(a_wrap, pop, idx_ff == POS_START, "position did not wrap after end byte")

endmodule

`default_nettype wire

FILE: hw/rtl/modbus_request_framer_unit.sv
// Read-request framer: one request in, a 36-item wrapped frame with crc out.
// An accepted request is written into the queue; once it is at the head and the
//   output register is free or draining, its first frame byte is loaded into it.
// The sequencer sends one frame byte per cycle on the rsp port while a request
//   is pending and rsp_tready is held high; the queue holds QUEUE_DEPTH pending requests.
// Reset (synchronous): clears sequence counter, serial, queue and output valid.
`default_nettype none

module modbus_request_framer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: logger serial
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [15:0] start_register, [23:16] register_count
   // frame byte channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] frame_byte
   output logic             rsp_tlast    // last_byte
);
   import mbrf_pkg::*;

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             head_valid;
   request_desc_type push_desc;
   request_desc_type head_desc;

   // request intake
   mbrf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_full  (queue_full),
      .push        (push),
      .push_desc   (push_desc)
   );

   // pending requests
   mbrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // frame byte sequencer
   mbrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
